// ----- rtl/kdr_pkg.sv -----
// Package for the key debounce and repeat command unit.
// Holds the key count, register indexes, command codes and the lane result struct.
// No dependencies.
package kdr_pkg;

   // Number of keys, one lane per key.
   localparam int unsigned NumKeys = 4;

   // Lane positions of the four keys.
   localparam int unsigned KeySelect = 0;
   localparam int unsigned KeyAbort  = 1;
   localparam int unsigned KeyPrev   = 2;
   localparam int unsigned KeyNext   = 3;

   // Configuration register indexes.
   localparam logic [1:0] RegRepeatStart = 2'd0;
   localparam logic [1:0] RegRepeatNext  = 2'd1;
   localparam logic [1:0] RegInvert      = 2'd2;

   // Configuration reset values.
   localparam logic [7:0] RepeatStartReset = 8'd50;
   localparam logic [7:0] RepeatNextReset  = 8'd20;
   localparam logic       InvertReset      = 1'b1;

   // Command codes delivered with each item.
   typedef enum logic [2:0] {
      CMD_NONE         = 3'd0,
      CMD_SELECT       = 3'd1,
      CMD_ABORT        = 3'd2,
      CMD_SELECT_LONG  = 3'd3,
      CMD_ABORT_LONG   = 3'd4,
      CMD_PREVIOUS     = 3'd5,
      CMD_NEXT         = 3'd6
   } kdr_cmd_type;

   // What one lane found on this item.
   typedef struct packed {
      logic short_hit;
      logic long_hit;
   } kdr_hit_type;

endpackage

// ----- rtl/key_debounce_repeat_commands_unit.sv -----
// Key debounce and repeat command unit: one result per item. Each accepted
// item's result is registered in the single result register, which holds while
// stalled; throughput is one item per cycle while that register is not stalled.
// Synchronous active-high reset clears the debounce, flag and countdown state and
// loads the configuration defaults. Depends on kdr_pkg, kdr_lane and kdr_merge.
module key_debounce_repeat_commands_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [3:0] req_raw_keys,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_command,
   output logic [3:0] rsp_debounced_keys,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_write_data
);

   logic [7:0] start_ff, start_in;
   logic [7:0] next_ff, next_in;
   logic       invert_ff, invert_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_command_ff, rsp_command_in;
   logic [3:0] rsp_keys_ff, rsp_keys_in;
   logic       accept;
   logic       expire;
   logic [kdr_pkg::NumKeys-1:0]           db_next;
   kdr_pkg::kdr_hit_type [kdr_pkg::NumKeys-1:0] hits;
   kdr_pkg::kdr_cmd_type                  command;

   // Configuration registers.
   always_comb begin
      start_in  = start_ff;
      next_in   = next_ff;
      invert_in = invert_ff;
      if (csr_write_enable) begin
         case (csr_index)
            kdr_pkg::RegRepeatStart: start_in  = csr_write_data;
            kdr_pkg::RegRepeatNext:  next_in   = csr_write_data;
            kdr_pkg::RegInvert:      invert_in = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= kdr_pkg::RepeatStartReset;
         next_ff   <= kdr_pkg::RepeatNextReset;
         invert_ff <= kdr_pkg::InvertReset;
      end else begin
         start_ff  <= start_in;
         next_ff   <= next_in;
         invert_ff <= invert_in;
      end
   end

   // An item enters whenever the result register is empty or being drained.
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;

   // One lane per key; previous and next use the step-key flag rules.
   for (genvar k = 0; k < kdr_pkg::NumKeys; k++) begin : g_lane
      kdr_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .enable   (accept),
         .step_key ((k == kdr_pkg::KeyPrev) || (k == kdr_pkg::KeyNext)),
         .raw_key  (req_raw_keys[k]),
         .invert   (invert_ff),
         .expire   (expire),
         .db_next  (db_next[k]),
         .hit      (hits[k])
      );
   end

   kdr_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .enable       (accept),
      .start_delay  (start_ff),
      .repeat_next  (next_ff),
      .db_next      (db_next),
      .hits         (hits),
      .expire       (expire),
      .command      (command)
   );

   // Result register.
   always_comb begin
      rsp_valid_in   = accept | (rsp_valid_ff & ~rsp_ready);
      rsp_command_in = accept ? command : rsp_command_ff;
      rsp_keys_in    = accept ? db_next : rsp_keys_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_command_ff <= rsp_command_in;
      rsp_keys_ff    <= rsp_keys_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_command        = rsp_command_ff;
   assign rsp_debounced_keys = rsp_keys_ff;

endmodule

// ----- rtl/kdr_lane.sv -----
// One key lane: vertical counter debounce, press detect and flag consumption.
// Depends on kdr_pkg for the lane result struct.
module kdr_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  step_key,
   input  logic                  raw_key,
   input  logic                  invert,
   input  logic                  expire,
   output logic                  db_next,
   output kdr_pkg::kdr_hit_type  hit
);

   logic db_ff, db_in;
   logic cl_ff, cl_in;
   logic ch_ff, ch_in;
   logic press_ff, press_in;
   logic rep_ff, rep_in;
   logic level, diff, toggle, press_set, rep_set;

   // Two-bit vertical counter; the level toggles after four agreeing items.
   always_comb begin
      level  = raw_key ^ invert;
      diff   = db_ff ^ level;
      cl_in  = ~(cl_ff & diff);
      ch_in  = cl_in ^ (ch_ff & diff);
      toggle = diff & cl_in & ch_in;
      db_in  = db_ff ^ toggle;
   end

   assign db_next = db_in;

   // Flags after press detect and repeat latch, then consumed by the decoder.
   always_comb begin
      press_set = press_ff | (db_in & toggle);
      rep_set   = rep_ff | (expire & db_in);
      hit       = '0;
      if (step_key) begin
         // Previous and next: a press is taken first, the repeat only without one.
         hit.short_hit = press_set | rep_set;
         press_in      = 1'b0;
         rep_in        = rep_set & press_set;
      end else begin
         // Select and abort: short on release, long when a repeat meets a press.
         hit.short_hit = press_set & ~db_in;
         hit.long_hit  = press_set & db_in & rep_set;
         press_in      = press_set & db_in & ~rep_set;
         rep_in        = 1'b0;
      end
   end

   // Lane state advances on each accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         db_ff    <= 1'b0;
         cl_ff    <= 1'b0;
         ch_ff    <= 1'b0;
         press_ff <= 1'b0;
         rep_ff   <= 1'b0;
      end else if (enable) begin
         db_ff    <= db_in;
         cl_ff    <= cl_in;
         ch_ff    <= ch_in;
         press_ff <= press_in;
         rep_ff   <= rep_in;
      end
   end

endmodule

// ----- rtl/kdr_merge.sv -----
// Merge stage: shared repeat countdown and command selection over the lanes.
// Depends on kdr_pkg for key positions, command codes and the lane result struct.
module kdr_merge (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  enable,
   input  logic [7:0]                            start_delay,
   input  logic [7:0]                            repeat_next,
   input  logic [kdr_pkg::NumKeys-1:0]           db_next,
   input  kdr_pkg::kdr_hit_type [kdr_pkg::NumKeys-1:0] hits,
   output logic                                  expire,
   output kdr_pkg::kdr_cmd_type                  command
);

   logic [7:0] count_ff, count_in;
   logic [7:0] count_base, count_dec;

   // Countdown restarts while no key is held and reloads when it expires.
   always_comb begin
      count_base = (db_next == '0) ? start_delay : count_ff;
      count_dec  = count_base - 8'd1;
      expire     = (count_dec == 8'd0);
      count_in   = expire ? repeat_next : count_dec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 8'd0;
      end else if (enable) begin
         count_ff <= count_in;
      end
   end

   // The last applicable command in decode order wins.
   always_comb begin
      if (hits[kdr_pkg::KeyNext].short_hit) begin
         command = kdr_pkg::CMD_NEXT;
      end else if (hits[kdr_pkg::KeyPrev].short_hit) begin
         command = kdr_pkg::CMD_PREVIOUS;
      end else if (hits[kdr_pkg::KeyAbort].long_hit) begin
         command = kdr_pkg::CMD_ABORT_LONG;
      end else if (hits[kdr_pkg::KeySelect].long_hit) begin
         command = kdr_pkg::CMD_SELECT_LONG;
      end else if (hits[kdr_pkg::KeyAbort].short_hit) begin
         command = kdr_pkg::CMD_ABORT;
      end else if (hits[kdr_pkg::KeySelect].short_hit) begin
         command = kdr_pkg::CMD_SELECT;
      end else begin
         command = kdr_pkg::CMD_NONE;
      end
   end

endmodule
